// ----- src/spq_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the priority queue.
package spq_pkg;

  localparam int Depth = 16;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 8;
  localparam int PriW  = 16;
  localparam int StatW = 2;
  localparam int OccW  = 5;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [StatW-1:0] STATUS_ENQUEUED = 2'd0;
  localparam logic [StatW-1:0] STATUS_DEQUEUED = 2'd1;
  localparam logic [StatW-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [StatW-1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic             load;
    logic             push;
    logic             pop;
    logic [StatW-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ----- src/spq_ctrl.sv -----
// Handshake controller: accepts operations and holds the result transfer.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spq_pkg::dp_stat_t dp_stat_i,
  output spq_pkg::cmd_t     cmd_o
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.push   = 1'b0;
    cmd_o.pop    = 1'b0;
    cmd_o.status = STATUS_ENQUEUED;
    if (opcode_i == OP_ENQUEUE) begin
      if (dp_stat_i.full) begin
        cmd_o.status = STATUS_FULL;
      end else begin
        cmd_o.push   = accept;
        cmd_o.status = STATUS_ENQUEUED;
      end
    end else begin
      if (dp_stat_i.empty) begin
        cmd_o.status = STATUS_EMPTY;
      end else begin
        cmd_o.pop    = accept;
        cmd_o.status = STATUS_DEQUEUED;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_d = S_HOLD;
        else if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/spq_datapath.sv -----
// Sorted shift-register entry array with count and result registers.
module spq_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::cmd_t             cmd_i,
  input  logic [spq_pkg::DataW-1:0] item_data_i,
  input  logic [spq_pkg::PriW-1:0]  item_priority_i,
  output spq_pkg::dp_stat_t         dp_stat_o,
  output logic [spq_pkg::DataW-1:0] out_data_o,
  output logic [spq_pkg::PriW-1:0]  out_priority_o,
  output logic [spq_pkg::StatW-1:0] status_o,
  output logic [spq_pkg::OccW-1:0]  occupancy_o
);
  import spq_pkg::*;

  logic [DataW-1:0] data_q [Depth];
  logic [DataW-1:0] data_d [Depth];
  logic [PriW-1:0]  pri_q  [Depth];
  logic [PriW-1:0]  pri_d  [Depth];
  logic [Depth-1:0] le;
  logic [CntW-1:0]  count_q, count_d;

  logic [DataW-1:0] res_data_q;
  logic [PriW-1:0]  res_pri_q;
  logic [StatW-1:0] res_stat_q;

  assign dp_stat_o.full  = (count_q == CntW'(Depth));
  assign dp_stat_o.empty = (count_q == '0);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      le[i] = (CntW'(i) < count_q) && (pri_q[i] <= item_priority_i);
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      data_d[i] = data_q[i];
      pri_d[i]  = pri_q[i];
    end
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
      if (!le[0]) begin
        data_d[0] = item_data_i;
        pri_d[0]  = item_priority_i;
      end
      for (int i = 1; i < Depth; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            data_d[i] = item_data_i;
            pri_d[i]  = item_priority_i;
          end else begin
            data_d[i] = data_q[i-1];
            pri_d[i]  = pri_q[i-1];
          end
        end
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
      for (int i = 0; i < Depth - 1; i++) begin
        data_d[i] = data_q[i+1];
        pri_d[i]  = pri_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      data_q[i] <= data_d[i];
      pri_q[i]  <= pri_d[i];
    end
    if (cmd_i.load) begin
      res_data_q <= cmd_i.pop ? data_q[0] : '0;
      res_pri_q  <= cmd_i.pop ? pri_q[0] : '0;
      res_stat_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign out_data_o     = res_data_q;
  assign out_priority_o = res_pri_q;
  assign status_o       = res_stat_q;
  assign occupancy_o    = OccW'(count_q);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds depth");

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.pop))
    else $error("push and pop in the same cycle");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not advance the count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not drop the count");
`endif

endmodule

// ----- src/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: controller plus entry datapath.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one operation per transfer:
//   opcode_i selects enqueue or dequeue, item_data_i and item_priority_i give
//   the item. Output channel (out_valid_o / out_ready_i) returns exactly one
//   result per operation: dequeued byte and priority (zero otherwise), a
//   status code and the occupancy after the operation.
//   The result is valid the cycle after the input transfer. Throughput is
//   one operation per cycle while the receiver takes each result; every
//   entry compares against the new priority in parallel and the whole
//   sorted array shifts together.
//   An enqueue lands behind all stored items of lower or equal priority, so
//   equal priorities leave in arrival order. A full queue drops the item and
//   reports full; an empty queue reports empty on dequeue.
//   Reset empties the queue at once and drops the pending result.
//   When the receiver stalls, the result register holds and in_ready_o stays
//   low until the result transfer completes.
module sorted_priority_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [spq_pkg::DataW-1:0] item_data_i,
  input  logic [spq_pkg::PriW-1:0]  item_priority_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [spq_pkg::DataW-1:0] out_data_o,
  output logic [spq_pkg::PriW-1:0]  out_priority_o,
  output logic [spq_pkg::StatW-1:0] status_o,
  output logic [spq_pkg::OccW-1:0]  occupancy_o
);
  import spq_pkg::*;

  cmd_t     cmd;
  dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_stat_i   (dp_stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_data_i     (item_data_i),
    .item_priority_i (item_priority_i),
    .dp_stat_o       (dp_stat),
    .out_data_o      (out_data_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

endmodule
